// ===== sv/mbbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbbs_pkg
// Shared types and constants for the mesh bounding box and sphere block.
// ----------------------------------------------------------------------------
package mbbs_pkg;

   localparam int COORD_BITS = 24;
   localparam int AXES       = 3;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int CNT_BITS   = $clog2(COORD_BITS);
   localparam int AXIS_BITS  = 2;

   localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_BITS-1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic                         last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] box_min_x;
      logic signed [COORD_BITS-1:0] box_min_y;
      logic signed [COORD_BITS-1:0] box_min_z;
      logic signed [COORD_BITS-1:0] box_max_x;
      logic signed [COORD_BITS-1:0] box_max_y;
      logic signed [COORD_BITS-1:0] box_max_z;
      logic signed [COORD_BITS-1:0] center_x;
      logic signed [COORD_BITS-1:0] center_y;
      logic signed [COORD_BITS-1:0] center_z;
      logic        [COORD_BITS-1:0] radius;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_CENTRE,
      ST_SQUARE,
      ST_ROOT,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic                 vertex_load;
      logic                 last;
      logic                 centre_load;
      logic                 square_en;
      logic [AXIS_BITS-1:0] axis_sel;
      logic                 root_step;
      logic                 result_load;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } sts_type;

endpackage

// ===== sv/mbbs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbbs_ctrl
// Sequencer: vertex intake, centre, three squares, root digits, result load.
// ----------------------------------------------------------------------------
module mbbs_ctrl
   import mbbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [CNT_BITS-1:0] SQ_LAST   = CNT_BITS'(AXES - 1);
   localparam logic [CNT_BITS-1:0] ROOT_LAST = CNT_BITS'(COORD_BITS - 1);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.last  = req_last;
      cmd.axis_sel = cnt_ff[AXIS_BITS-1:0];
      case (state_ff)
         ST_ACCUM: begin
            req_stall       = 1'b0;
            cmd.vertex_load = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_CENTRE;
            end
         end
         ST_CENTRE: begin
            cmd.centre_load = 1'b1;
            cnt_in          = '0;
            state_in        = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square_en = 1'b1;
            if (cnt_ff == SQ_LAST) begin
               cnt_in   = '0;
               state_in = ST_ROOT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == ROOT_LAST) begin
               cnt_in   = '0;
               state_in = ST_OUTPUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_OUTPUT: begin
            if (!sts.out_full) begin
               cmd.result_load = 1'b1;
               state_in        = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
            cnt_in   = '0;
         end
      endcase
   end

   // the closing vertex always starts the sphere sequence
   a_last_starts_centre: assert property (@(posedge clock) disable iff (reset)
      cmd.vertex_load && cmd.last |=> state_ff == ST_CENTRE)
      else $error("last vertex did not start centre step");

   // root digits never run past the coordinate width
   a_root_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROOT |-> cnt_ff <= ROOT_LAST)
      else $error("root digit count out of range");

endmodule

// ===== sv/mbbs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbbs_dp
// Datapath: running min/max, centre and offsets, squared sum, digit-by-digit
// square root and the result register.
// ----------------------------------------------------------------------------
module mbbs_dp
   import mbbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_payload,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic signed [COORD_BITS-1:0] pos [AXES];
   logic signed [COORD_BITS-1:0] min_ff [AXES];
   logic signed [COORD_BITS-1:0] min_in [AXES];
   logic signed [COORD_BITS-1:0] max_ff [AXES];
   logic signed [COORD_BITS-1:0] max_in [AXES];
   logic signed [COORD_BITS-1:0] centre_ff [AXES];
   logic signed [COORD_BITS-1:0] centre_in [AXES];
   logic        [COORD_BITS-1:0] off_ff [AXES];
   logic        [COORD_BITS-1:0] off_in [AXES];
   logic        [COORD_BITS:0]   pair_sum [AXES];
   logic        [COORD_BITS:0]   span [AXES];

   logic                  run_open_ff, run_open_in;
   logic [COORD_BITS-1:0] off_sel;
   logic [SQ_BITS-1:0]    sq;
   logic [SQ_BITS-1:0]    sum_ff, sum_in;
   logic [COORD_BITS+1:0] rem_ff, rem_in;
   logic [COORD_BITS+1:0] rem_shift, trial;
   logic [COORD_BITS-1:0] root_ff, root_in;
   logic                  digit;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   assign pos[AXIS_X] = req_payload.pos_x;
   assign pos[AXIS_Y] = req_payload.pos_y;
   assign pos[AXIS_Z] = req_payload.pos_z;

   // min/max widening, centre and half-span per axis
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         if (!run_open_ff) begin
            min_in[i] = pos[i];
            max_in[i] = pos[i];
         end else begin
            min_in[i] = (pos[i] < min_ff[i]) ? pos[i] : min_ff[i];
            max_in[i] = (pos[i] > max_ff[i]) ? pos[i] : max_ff[i];
         end
         pair_sum[i]  = {min_ff[i][COORD_BITS-1], min_ff[i]}
                      + {max_ff[i][COORD_BITS-1], max_ff[i]};
         centre_in[i] = pair_sum[i][COORD_BITS:1];
         // max - floor((min+max)/2) equals (max - min + 1) / 2
         span[i]      = {max_ff[i][COORD_BITS-1], max_ff[i]}
                      - {min_ff[i][COORD_BITS-1], min_ff[i]}
                      + (COORD_BITS+1)'(1);
         off_in[i]    = span[i][COORD_BITS:1];
      end
   end

   assign run_open_in = !cmd.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff <= 1'b0;
      end else if (cmd.vertex_load) begin
         run_open_ff <= run_open_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < AXES; i++) begin
         if (cmd.vertex_load) begin
            min_ff[i] <= min_in[i];
            max_ff[i] <= max_in[i];
         end
         if (cmd.centre_load) begin
            centre_ff[i] <= centre_in[i];
            off_ff[i]    <= off_in[i];
         end
      end
   end

   // one axis squared per cycle
   always_comb begin
      case (cmd.axis_sel)
         AXIS_X:  off_sel = off_ff[AXIS_X];
         AXIS_Y:  off_sel = off_ff[AXIS_Y];
         default: off_sel = off_ff[AXIS_Z];
      endcase
   end

   assign sq = SQ_BITS'(off_sel) * SQ_BITS'(off_sel);

   // restoring square root, two radicand bits a step
   assign rem_shift = {rem_ff[COORD_BITS-1:0], sum_ff[SQ_BITS-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign digit     = rem_shift >= trial;

   always_comb begin
      sum_in  = sum_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.square_en) begin
         sum_in  = (cmd.axis_sel == AXIS_X) ? sq : sum_ff + sq;
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.root_step) begin
         sum_in  = {sum_ff[SQ_BITS-3:0], 2'b00};
         rem_in  = digit ? rem_shift - trial : rem_shift;
         root_in = {root_ff[COORD_BITS-2:0], digit};
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   // result register
   always_comb begin
      rsp_in.box_min_x = min_ff[AXIS_X];
      rsp_in.box_min_y = min_ff[AXIS_Y];
      rsp_in.box_min_z = min_ff[AXIS_Z];
      rsp_in.box_max_x = max_ff[AXIS_X];
      rsp_in.box_max_y = max_ff[AXIS_Y];
      rsp_in.box_max_z = max_ff[AXIS_Z];
      rsp_in.center_x  = centre_ff[AXIS_X];
      rsp_in.center_y  = centre_ff[AXIS_Y];
      rsp_in.center_z  = centre_ff[AXIS_Z];
      rsp_in.radius    = root_ff;
   end

   assign sts.out_full  = rsp_valid_ff && rsp_stall;
   assign rsp_valid_in  = cmd.result_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a run only closes on a vertex marked last
   a_run_close: assert property (@(posedge clock) disable iff (reset)
      $fell(run_open_ff) |-> $past(cmd.vertex_load && cmd.last))
      else $error("run closed without last vertex");

   // box is never inverted
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.box_min_x <= rsp_ff.box_max_x
                    && rsp_ff.box_min_y <= rsp_ff.box_max_y
                    && rsp_ff.box_min_z <= rsp_ff.box_max_z)
      else $error("box min above max");

   // centre lies inside the box
   a_centre_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.center_x >= rsp_ff.box_min_x
                    && rsp_ff.center_x <= rsp_ff.box_max_x
                    && rsp_ff.center_y >= rsp_ff.box_min_y
                    && rsp_ff.center_y <= rsp_ff.box_max_y
                    && rsp_ff.center_z >= rsp_ff.box_min_z
                    && rsp_ff.center_z <= rsp_ff.box_max_z)
      else $error("centre outside box");

endmodule

// ===== sv/mesh_bounds_box_sphere.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_bounds_box_sphere
// Bounding box, centre and bounding sphere radius of a vertex stream.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          beat
//  req_      in         req_valid/stall    one vertex, last_vertex closes run
//  rsp_      out        rsp_valid/stall    box, centre and radius of one run
//
//  vertices are taken one per cycle while a run is open
//  after the last vertex the input stalls through the sphere steps:
//  centre, three squares on one multiplier, one root digit per cycle, load
//  a result waiting on rsp_stall holds the block in its load step only
//  reset clears the run and the result valid; box and result bits are not reset
// ----------------------------------------------------------------------------
module mesh_bounds_box_sphere
   import mbbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type cmd;
   sts_type sts;

   mbbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last_vertex),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mbbs_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
